[src/rvbd_pkg.sv]
// Shared types and constants of the rolling volatility burst detector.
// Depends on nothing; used by rolling_volatility_burst_detector in src.
`default_nettype none
package rvbd_pkg;
   localparam int PRICE_W = 24;
   localparam int TIME_W  = 64;
   localparam int MIN_HELD = 5;
   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = PRICE_W;
   localparam logic [1:0] CSR_WINDOW    = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD = 2'd1;

   typedef struct packed {
      logic [PRICE_W-1:0] mid_price;
      logic [TIME_W-1:0]  time_stamp;
   } req_type;

   typedef struct packed {
      logic               ready_res;
      logic [31:0]        sigma;
      logic [31:0]        burst_ratio;
      logic signed [31:0] z_score;
      logic               bursting;
      logic [TIME_W-1:0]  result_time;
   } rsp_type;
endpackage
`default_nettype wire

[src/rvbd_divider.sv]
// Restoring divider, one quotient bit per cycle, shared by the variance, burst and z divisions.
// Depends on nothing from the package.
`default_nettype none
module rvbd_divider #(
   parameter int NUM_W = 128,
   parameter int DEN_W = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] numer,
   input  wire logic [DEN_W-1:0] denom,
   output logic                  done,
   output logic [NUM_W-1:0]      quot
);
   localparam int CW = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] num_ff, num_in;
   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      num_in = num_ff; q_in = q_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[DEN_W-1:0], num_ff[NUM_W-1]};
      if (start) begin
         num_in = numer; q_in = '0; rem_in = '0;
         cnt_in = CW'(NUM_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) den_ff <= denom;
      num_ff <= num_in; q_ff <= q_in; rem_ff <= rem_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

[src/rolling_volatility_burst_detector.sv]
// Rolling volatility burst detector: ring memory walk, variance, sqrt, divisions.
// Depends on rvbd_pkg and rvbd_divider.
//
// Usage: one beat on req_ carries a price and a timestamp; one beat on rsp_
// follows. The price is written into a ring memory (a synchronous write port
// and a registered read port); the newest held samples are then walked one a
// cycle to build the sum and sum of squares.
// The variance, burst and z-score divisions run on the shared 128-step serial
// divider; between them the 63-step square root works a 64-bit square split in
// four 32-bit products per step, plus one end step. With fewer than five
// samples the result goes straight to the output. req_ready is high whenever
// no item is in work, so the next beat is taken only once the last is through;
// a result waiting on rsp_ready holds in the output register and the next item
// stalls at its end until it goes.
// Reset clears the slot, count and control; the ring contents are not cleared.
// csr_ index 0 writes window_length, index 1 burst_threshold.
`default_nettype none
module rolling_volatility_burst_detector (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rvbd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rvbd_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_wdata
);
   localparam int MAX_WINDOW  = rvbd_pkg::MAX_WINDOW;
   localparam int SAMPLE_BITS = rvbd_pkg::SAMPLE_BITS;
   localparam int AW = $clog2(MAX_WINDOW);
   localparam int NW = $clog2(MAX_WINDOW + 1);
   localparam int SW = SAMPLE_BITS + NW;        // sum width
   localparam int QW = 2 * SAMPLE_BITS + NW;    // sum of squares width

   localparam logic [3:0] ST_IDLE = 4'd0, ST_WRITE = 4'd1, ST_READ = 4'd2,
      ST_ACC = 4'd3, ST_VAR = 4'd4, ST_VDIV = 4'd5, ST_SQRT = 4'd6,
      ST_SQ2 = 4'd7, ST_BDIV = 4'd8, ST_ZDIV = 4'd9, ST_OUT = 4'd10,
      ST_MUL = 4'd11, ST_VAR2 = 4'd12;

   logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;

   logic [3:0]  st_ff;
   logic [AW-1:0] slot_ff, idx_ff;
   logic [NW-1:0] held_ff, cnt_ff, win_ff, win_eff, held_in;
   logic [31:0] thr_ff;
   logic [SAMPLE_BITS-1:0] x_ff, last_ff, prev_ff;
   logic [rvbd_pkg::TIME_W-1:0] ts_ff;
   logic [SW-1:0] sum_ff;
   logic [QW-1:0] sq_ff;
   logic [127:0]  wide_ff;
   logic [63:0]   root_ff, cand_ff, sig_ff;
   logic [5:0]    bit_ff;
   logic [1:0]    part_ff;
   logic [63:0]   pp_ff;
   logic          out_v_ff;
   logic          out_load;
   rvbd_pkg::rsp_type out_ff;
   logic [31:0]   burst_ff;

   logic          div_start, div_done;
   logic [127:0]  div_num, div_q;
   logic [63:0]   div_den;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= NW'(30); thr_ff <= 32'd131072;
      end else if (csr_write) begin
         if (csr_index == rvbd_pkg::CSR_WINDOW) win_ff <= NW'(csr_wdata[6:0]);
         else if (csr_index == rvbd_pkg::CSR_THRESHOLD) thr_ff <= csr_wdata;
      end
   end

   assign win_eff = ({25'd0, win_ff} > 32'(MAX_WINDOW)) ? NW'(MAX_WINDOW) : win_ff;
   assign held_in = ({25'd0, held_ff} + 32'd1 > {25'd0, win_eff}) ? win_eff
                    : held_ff + NW'(1);

   assign wr_en   = (st_ff == ST_WRITE);
   assign rd_addr = idx_ff;
   always_ff @(posedge clock) begin
      if (wr_en) ring[slot_ff] <= x_ff;
      rd_ff <= ring[rd_addr];
   end

   rvbd_divider #(.NUM_W(128), .DEN_W(64)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(div_num),
      .denom(div_den), .done(div_done), .quot(div_q));

   // step multiplier over 32-bit halves of cand
   logic [31:0] ma, mb;
   always_comb begin
      case (part_ff)
         2'd0: begin ma = cand_ff[31:0];  mb = cand_ff[31:0];  end
         2'd1: begin ma = cand_ff[31:0];  mb = cand_ff[63:32]; end
         2'd2: begin ma = cand_ff[63:32]; mb = cand_ff[31:0];  end
         default: begin ma = cand_ff[63:32]; mb = cand_ff[63:32]; end
      endcase
   end
   logic [127:0] sqacc_ff;
   logic [63:0]  step_abs, zn_abs, n_last;
   logic         zneg;
   assign step_abs = (last_ff >= prev_ff) ? 64'(last_ff - prev_ff) : 64'(prev_ff - last_ff);
   assign n_last   = 64'(last_ff) * 64'(held_ff);
   assign zneg     = n_last < 64'(sum_ff);
   assign zn_abs   = zneg ? 64'(sum_ff) - n_last : n_last - 64'(sum_ff);

   always_comb begin
      div_start = 1'b0; div_num = '0; div_den = '0;
      case (st_ff)
         ST_VAR: begin
            div_start = 1'b1;
            div_num = wide_ff << 16;
            div_den = 64'(held_ff) * 64'(held_ff);
         end
         ST_SQ2: if (bit_ff == 6'd63) begin
            div_start = 1'b1;
            div_num = {40'd0, step_abs, 24'd0};
            div_den = sig_ff;
         end
         default: ;
      endcase
      if (st_ff == ST_BDIV && div_done) begin
         div_start = 1'b1;
         div_num = {40'd0, zn_abs, 24'd0};
         div_den = 64'(held_ff) * sig_ff;
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: if (req_valid && req_ready) begin
            x_ff <= req_data.mid_price[SAMPLE_BITS-1:0];
            ts_ff <= req_data.time_stamp;
         end
         ST_WRITE: begin
            idx_ff <= slot_ff; sum_ff <= '0; sq_ff <= '0;
            cnt_ff <= '0;
         end
         ST_READ: idx_ff <= (idx_ff == '0) ? AW'(MAX_WINDOW - 1) : idx_ff - AW'(1);
         ST_ACC: begin
            sum_ff <= sum_ff + SW'(rd_ff);
            sq_ff  <= sq_ff + QW'(64'(rd_ff) * 64'(rd_ff));
            if (cnt_ff == NW'(0)) last_ff <= rd_ff;
            if (cnt_ff == NW'(1)) prev_ff <= rd_ff;
            cnt_ff <= cnt_ff + NW'(1);
            idx_ff <= (idx_ff == '0) ? AW'(MAX_WINDOW - 1) : idx_ff - AW'(1);
         end
         ST_MUL: wide_ff <= 128'(sq_ff) * 128'(held_ff);
         ST_VAR2: wide_ff <= wide_ff - 128'(64'(sum_ff) * 64'(sum_ff));
         ST_VDIV: if (div_done) begin
            wide_ff <= div_q; root_ff <= '0; bit_ff <= 6'd62;
            cand_ff <= 64'd1 << 62; part_ff <= '0; sqacc_ff <= '0;
         end
         ST_SQRT: begin
            pp_ff <= ma * mb;
            if (part_ff == 2'd0) sqacc_ff <= '0;
            else sqacc_ff <= sqacc_ff + (128'(pp_ff) << ((part_ff == 2'd1) ? 0 : 32));
            part_ff <= part_ff + 2'd1;
         end
         ST_SQ2: begin
            // bit 0 wraps to 63, the end mark
            if (bit_ff != 6'd63) begin
               if (sqacc_ff + (128'(pp_ff) << 64) <= wide_ff) root_ff <= cand_ff;
               part_ff <= '0;
               bit_ff <= bit_ff - 6'd1;
               cand_ff <= (sqacc_ff + (128'(pp_ff) << 64) <= wide_ff)
                  ? (cand_ff | (64'd1 << (bit_ff - 6'd1)))
                  : (root_ff | (64'd1 << (bit_ff - 6'd1)));
            end
         end
         ST_BDIV: if (div_done) burst_ff <= (|div_q[127:32]) ? 32'hFFFFFFFF : div_q[31:0];
         default: ;
      endcase
   end

   // the last sqrt step sets sig when bit wraps
   always_ff @(posedge clock) begin
      if (st_ff == ST_SQ2 && bit_ff == 6'd0)
         sig_ff <= (sqacc_ff + (128'(pp_ff) << 64) <= wide_ff)
            ? ((|cand_ff[63:32]) ? 64'hFFFFFFFF : cand_ff)
            : ((|root_ff[63:32]) ? 64'hFFFFFFFF : root_ff);
   end

   logic [31:0] burst_fin, z_fin;
   logic [63:0] zq;
   always_comb begin
      if (step_abs == '0) burst_fin = '0;
      else if (sig_ff == '0) burst_fin = 32'hFFFFFFFF;
      else burst_fin = burst_ff;
      if (zn_abs == '0) zq = '0;
      else if (sig_ff == '0) zq = 64'd1 << 40;
      else zq = (|div_q[127:64]) ? 64'd1 << 40 : div_q[63:0];
      if (!zneg) z_fin = (zq > 64'h7FFFFFFF) ? 32'h7FFFFFFF : zq[31:0];
      else z_fin = (zq > 64'h80000000) ? 32'h80000000 : (32'd0 - zq[31:0]);
   end

   assign out_load = (st_ff == ST_OUT) && (!out_v_ff || rsp_ready);

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; slot_ff <= '0; held_ff <= '0; out_v_ff <= 1'b0;
      end else begin
         case (st_ff)
            ST_IDLE: if (req_valid && req_ready) st_ff <= ST_WRITE;
            ST_WRITE: begin
               slot_ff <= (32'(slot_ff) + 1 >= MAX_WINDOW) ? '0 : slot_ff + AW'(1);
               held_ff <= held_in;
               st_ff <= ({25'd0, held_in} < 32'(rvbd_pkg::MIN_HELD)) ? ST_OUT : ST_READ;
            end
            ST_READ: st_ff <= ST_ACC;
            ST_ACC: if (cnt_ff + NW'(1) == held_ff) st_ff <= ST_MUL;
            ST_MUL: st_ff <= ST_VAR2;
            ST_VAR2: st_ff <= ST_VAR;
            ST_VAR: st_ff <= ST_VDIV;
            ST_VDIV: if (div_done) st_ff <= ST_SQRT;
            ST_SQRT: if (part_ff == 2'd3) st_ff <= ST_SQ2;
            ST_SQ2: st_ff <= (bit_ff == 6'd63) ? ST_BDIV
                             : (bit_ff == 6'd0) ? ST_SQ2 : ST_SQRT;
            ST_BDIV: if (div_done) st_ff <= ST_ZDIV;
            ST_ZDIV: if (div_done) st_ff <= ST_OUT;
            ST_OUT: if (out_load) st_ff <= ST_IDLE;
            default: st_ff <= ST_IDLE;
         endcase
         if (out_load) out_v_ff <= 1'b1;
         else if (out_v_ff && rsp_ready) out_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff.result_time <= ts_ff;
         if ({25'd0, held_ff} < 32'(rvbd_pkg::MIN_HELD)) begin
            out_ff.ready_res <= 1'b0; out_ff.sigma <= '0; out_ff.burst_ratio <= '0;
            out_ff.z_score <= '0; out_ff.bursting <= 1'b0;
         end else begin
            out_ff.ready_res <= 1'b1; out_ff.sigma <= sig_ff[31:0];
            out_ff.burst_ratio <= burst_fin; out_ff.z_score <= z_fin;
            out_ff.bursting <= burst_fin >= thr_ff;
         end
      end
   end

   assign req_ready = (st_ff == ST_IDLE);
   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");
   a_held_limit: assert property (@(posedge clock) disable iff (reset)
      held_ff <= NW'(MAX_WINDOW)) else $error("held count beyond window");
   a_out_follows: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_OUT |=> rsp_valid) else $error("result lost");
endmodule
`default_nettype wire
